@@ hw/rtl/assert_macros.svh @@
// Concurrent assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with async active-low reset
`define AUV_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// signed Q1.30 value within [-1, 1]
`define AUV_ASSERT_UNIT(lbl, clk, rst_n, vld, val, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) \
		vld |-> ($signed(val) <= 32'sh4000_0000 && $signed(val) >= -32'sh4000_0000)) \
		else $error(msg);

`endif

@@ hw/rtl/auv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package auv_pkg;
	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
	localparam int unsigned DIV_STEPS = 31;

	typedef struct packed {
		logic nx;
		logic ny;
		logic nz;
		logic last;
	} vec_side_t;

	typedef struct packed {
		logic nx;
		logic nz;
		logic yneg;
		logic zero;
		logic last;
	} div_side_t;

	typedef struct packed {
		logic [61:0] rem;
		logic        qb;
	} dstep_t;

	// one restoring division step
	function automatic dstep_t div_step(logic [61:0] rem, logic [61:0] den);
		logic [62:0] sh;
		dstep_t      res;
		sh = {rem, 1'b0};
		if (sh >= {1'b0, den}) begin
			res.rem = 62'(sh - {1'b0, den});
			res.qb  = 1'b1;
		end else begin
			res.rem = sh[61:0];
			res.qb  = 1'b0;
		end
		return res;
	endfunction
endpackage
`default_nettype wire

@@ hw/rtl/auv_proj.sv @@
`timescale 1ns / 1ps
`default_nettype none
module auv_proj (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_vld,
	input  wire logic        [31:0] in_x,
	input  wire logic        [31:0] in_y,
	input  wire logic        [31:0] in_z,
	input  wire logic               in_last,
	input  wire logic        [31:0] k,
	output logic                    vld,
	output auv_pkg::div_side_t      side,
	output logic             [61:0] num_x,
	output logic             [61:0] num_y,
	output logic             [61:0] num_z,
	output logic             [61:0] den
);
	import auv_pkg::*;

	logic            vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	vec_side_t       side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	div_side_t       side_s7;
	logic [31:0]     mx_s1, mz_s1, t_s1;
	logic [63:0]     p_s2, r_s2, q_s2;
	logic [63:0]     p_s3, r_s3, q_s3;
	logic [5:0]      sh_s3, sh;
	logic [63:0]     m_or;
	logic [29:0]     p_s4, r_s4, q_s4;
	logic [59:0]     p2_s5, r2_s5, q2_s5, pq_s5, rq_s5;
	logic            zero_s5, zero_s6;
	logic [60:0]     pr_s6;
	logic [59:0]     q2_s6, pq_s6, rq_s6;
	logic [61:0]     den_s7, nx_s7, ny_s7, nz_s7;
	logic [31:0]     fa, fb;
	logic [61:0]     pr_w, q2_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// stage 1: magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= '{nx: in_x[31], ny: in_y[31], nz: in_z[31], last: in_last};
			mx_s1   <= in_x[31] ? (~in_x + 32'd1) : in_x;
			mz_s1   <= in_z[31] ? (~in_z + 32'd1) : in_z;
			t_s1    <= ONE_Q30 + (in_y[31] ? (~in_y + 32'd1) : in_y);
		end
	end

	// stage 2: projection products
	assign fa = side_s1.ny ? k : ONE_Q30;
	assign fb = side_s1.ny ? ONE_Q30 : k;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			p_s2    <= 64'(mx_s1) * 64'(fa);
			r_s2    <= 64'(mz_s1) * 64'(fa);
			q_s2    <= 64'(t_s1) * 64'(fb);
		end
	end

	// stage 3: normalize shift from the top set bit
	assign m_or = p_s2 | r_s2 | q_s2;

	always_comb begin
		sh = '0;
		for (int i = 30; i < 64; i++) begin
			if (m_or[i]) sh = 6'(i - 29);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_s2;
			p_s3    <= p_s2;
			r_s3    <= r_s2;
			q_s3    <= q_s2;
			sh_s3   <= sh;
		end
	end

	// stage 4: shift down to 30 bits
	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			p_s4    <= 30'(p_s3 >> sh_s3);
			r_s4    <= 30'(r_s3 >> sh_s3);
			q_s4    <= 30'(q_s3 >> sh_s3);
		end
	end

	// stage 5: squares and cross products
	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_s4;
			p2_s5   <= 60'(p_s4) * 60'(p_s4);
			r2_s5   <= 60'(r_s4) * 60'(r_s4);
			q2_s5   <= 60'(q_s4) * 60'(q_s4);
			pq_s5   <= 60'(p_s4) * 60'(q_s4);
			rq_s5   <= 60'(r_s4) * 60'(q_s4);
			zero_s5 <= (p_s4 | r_s4 | q_s4) == '0;
		end
	end

	// stage 6: partial sum
	always_ff @(posedge clk) begin
		if (en) begin
			side_s6 <= side_s5;
			pr_s6   <= {1'b0, p2_s5} + {1'b0, r2_s5};
			q2_s6   <= q2_s5;
			pq_s6   <= pq_s5;
			rq_s6   <= rq_s5;
			zero_s6 <= zero_s5;
		end
	end

	// stage 7: denominator, y numerator and the x and z numerators
	assign pr_w = {1'b0, pr_s6};
	assign q2_w = {2'b0, q2_s6};

	always_ff @(posedge clk) begin
		if (en) begin
			side_s7.nx   <= side_s6.nx;
			side_s7.nz   <= side_s6.nz;
			side_s7.yneg <= (q2_w >= pr_w) ? side_s6.ny : !side_s6.ny;
			side_s7.zero <= zero_s6;
			side_s7.last <= side_s6.last;
			den_s7       <= pr_w + q2_w;
			ny_s7        <= (q2_w >= pr_w) ? (q2_w - pr_w) : (pr_w - q2_w);
			nx_s7        <= {1'b0, pq_s6, 1'b0};
			nz_s7        <= {1'b0, rq_s6, 1'b0};
		end
	end

	assign vld   = vld_s7;
	assign side  = side_s7;
	assign num_x = nx_s7;
	assign num_y = ny_s7;
	assign num_z = nz_s7;
	assign den   = den_s7;
endmodule
`default_nettype wire

@@ hw/rtl/auv_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module auv_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_vld,
	input  wire auv_pkg::div_side_t in_side,
	input  wire logic        [61:0] num_x,
	input  wire logic        [61:0] num_y,
	input  wire logic        [61:0] num_z,
	input  wire logic        [61:0] den,
	output logic                    vld,
	output auv_pkg::div_side_t      side,
	output logic              [2:0] sat,
	output logic             [30:0] quo_x,
	output logic             [30:0] quo_y,
	output logic             [30:0] quo_z
);
	import auv_pkg::*;

	// index 0 is the load stage, then one stage per quotient bit
	logic        vld_s  [0:DIV_STEPS];
	div_side_t   side_s [0:DIV_STEPS];
	logic [2:0]  sat_s  [0:DIV_STEPS];
	logic [61:0] den_s  [0:DIV_STEPS];
	logic [61:0] rx_s   [0:DIV_STEPS];
	logic [61:0] ry_s   [0:DIV_STEPS];
	logic [61:0] rz_s   [0:DIV_STEPS];
	logic [30:0] qx_s   [0:DIV_STEPS];
	logic [30:0] qy_s   [0:DIV_STEPS];
	logic [30:0] qz_s   [0:DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			sat_s[0]  <= {num_z >= den, num_y >= den, num_x >= den};
			den_s[0]  <= den;
			rx_s[0]   <= num_x;
			ry_s[0]   <= num_y;
			rz_s[0]   <= num_z;
			qx_s[0]   <= '0;
			qy_s[0]   <= '0;
			qz_s[0]   <= '0;
		end
	end

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		dstep_t sx, sy, sz;

		assign sx = div_step(rx_s[i], den_s[i]);
		assign sy = div_step(ry_s[i], den_s[i]);
		assign sz = div_step(rz_s[i], den_s[i]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i+1] <= side_s[i];
				sat_s[i+1]  <= sat_s[i];
				den_s[i+1]  <= den_s[i];
				rx_s[i+1]   <= sx.rem;
				ry_s[i+1]   <= sy.rem;
				rz_s[i+1]   <= sz.rem;
				qx_s[i+1]   <= {qx_s[i][29:0], sx.qb};
				qy_s[i+1]   <= {qy_s[i][29:0], sy.qb};
				qz_s[i+1]   <= {qz_s[i][29:0], sz.qb};
			end
		end
	end

	assign vld   = vld_s[DIV_STEPS];
	assign side  = side_s[DIV_STEPS];
	assign sat   = sat_s[DIV_STEPS];
	assign quo_x = qx_s[DIV_STEPS];
	assign quo_y = qy_s[DIV_STEPS];
	assign quo_z = qz_s[DIV_STEPS];
endmodule
`default_nettype wire

@@ hw/rtl/aberration_unit_vector_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel | handshake            | payload
// in      | in_valid / in_ready  | in_x, in_y, in_z, in_last
// out     | out_valid / out_ready| out_x, out_y, out_z, out_last
// cfg     | cfg_we               | cfg_wdata (exp_rapidity)
// One item per cycle sustained while out_ready stays high; 7 projection stages,
// 32 divider stages, one output register. The divider does one quotient
// bit per stage for all three components.
// Reset clears valid bits and sets exp_rapidity to 1.0.
// A held output freezes the whole pipeline; in_ready drops only then.
module aberration_unit_vector_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic signed [31:0] in_x,
	input  wire logic signed [31:0] in_y,
	input  wire logic signed [31:0] in_z,
	input  wire logic        in_last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic             out_last,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata
);
	import auv_pkg::*;

	logic        en;
	logic [31:0] exp_rapidity_q;
	logic        p_vld, d_vld;
	div_side_t   p_side, d_side;
	logic [61:0] p_nx, p_ny, p_nz, p_den;
	logic [2:0]  d_sat;
	logic [30:0] d_qx, d_qy, d_qz;
	logic        out_valid_q, out_last_q;
	logic [31:0] out_x_q, out_y_q, out_z_q;

	function automatic logic [31:0] pack(logic neg, logic sat, logic [30:0] quo);
		logic [31:0] mag;
		mag = sat ? ONE_Q30 : (({1'b0, quo} + 32'd1) >> 1);
		return neg ? (~mag + 32'd1) : mag;
	endfunction

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_rapidity_q <= ONE_Q30;
		end else if (cfg_we) begin
			exp_rapidity_q <= cfg_wdata;
		end
	end

	auv_proj u_proj (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (in_valid),
		.in_x   (in_x),
		.in_y   (in_y),
		.in_z   (in_z),
		.in_last(in_last),
		.k      (exp_rapidity_q),
		.vld    (p_vld),
		.side   (p_side),
		.num_x  (p_nx),
		.num_y  (p_ny),
		.num_z  (p_nz),
		.den    (p_den)
	);

	auv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (p_vld),
		.in_side(p_side),
		.num_x  (p_nx),
		.num_y  (p_ny),
		.num_z  (p_nz),
		.den    (p_den),
		.vld    (d_vld),
		.side   (d_side),
		.sat    (d_sat),
		.quo_x  (d_qx),
		.quo_y  (d_qy),
		.quo_z  (d_qz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_last_q <= d_side.last;
			// all-zero projection: straight ahead
			if (d_side.zero) begin
				out_x_q <= '0;
				out_y_q <= ONE_Q30;
				out_z_q <= '0;
			end else begin
				out_x_q <= pack(d_side.nx, d_sat[0], d_qx);
				out_y_q <= pack(d_side.yneg, d_sat[1], d_qy);
				out_z_q <= pack(d_side.nz, d_sat[2], d_qz);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_last  = out_last_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;
endmodule
`default_nettype wire

@@ hw/rtl/auv_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module auv_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [31:0] in_x,
	input wire logic [31:0] in_y,
	input wire logic [31:0] in_z,
	input wire logic        in_last,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] out_x,
	input wire logic [31:0] out_y,
	input wire logic [31:0] out_z,
	input wire logic        out_last,
	input wire logic        cfg_we,
	input wire logic [31:0] cfg_wdata
);
	`AUV_ASSERT(a_ready_follows_out, clk, arst_n, in_ready == (!out_valid || out_ready), "in_ready mismatch")
	`AUV_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_y), "output changed while stalled")
	`AUV_ASSERT_UNIT(a_x_unit, clk, arst_n, out_valid, out_x, "out_x out of range")
	`AUV_ASSERT_UNIT(a_y_unit, clk, arst_n, out_valid, out_y, "out_y out of range")
endmodule

bind aberration_unit_vector_unit auv_checker u_auv_checker (.*);
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] in_x = '0, in_y = '0, in_z = '0;
	logic in_last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] out_x, out_y, out_z;
	logic out_last;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        last;
	} aberr_vec_t;

	localparam logic [31:0] ONE = 32'h4000_0000;
	localparam logic [31:0] MINUS_ONE = 32'hC000_0000;
	localparam int PIPE_LATENCY = 40;

	aberr_vec_t aberrated_q[$];
	logic [31:0] rapidity;
	int errors = 0;
	int sink_mode = 0; // 0 random stalls, 1 always ready, 2 long hold-off
	bit sender_idles = 1'b1;

	aberration_unit_vector_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_x(in_x), .in_y(in_y), .in_z(in_z), .in_last(in_last),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .out_z(out_z), .out_last(out_last),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// floor(2^31*num/den) by restoring division, then round half up
	function automatic logic [31:0] unit_ratio(logic [63:0] num, logic [63:0] den);
		logic [63:0] q, r;
		q = 0;
		r = num;
		if (den == 0) return 0;
		if (num >= den) return ONE;
		for (int i = 0; i < 31; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		return 32'((q + 1) >> 1);
	endfunction

	function automatic logic [31:0] apply_sign(logic neg, logic [31:0] mag);
		return neg ? -mag : mag;
	endfunction

	function automatic aberr_vec_t aberrate(aberr_vec_t v);
		aberr_vec_t o;
		logic nx, ny, nz, yneg;
		logic [63:0] mx, my, mz, k, p, r, q, m, p2, r2, q2, den, ym;
		int sh;
		nx = v.x[31];
		ny = v.y[31];
		nz = v.z[31];
		// magnitude of a 32-bit two's complement value, -2^31 gives 2^31
		mx = nx ? (64'h1_0000_0000 - 64'(v.x)) : 64'(v.x);
		my = ny ? (64'h1_0000_0000 - 64'(v.y)) : 64'(v.y);
		mz = nz ? (64'h1_0000_0000 - 64'(v.z)) : 64'(v.z);
		k = 64'(rapidity);
		if (ny) begin
			p = k * mx;
			r = k * mz;
			q = 64'(ONE) * (64'(ONE) + my);
		end else begin
			p = mx << 30;
			r = mz << 30;
			q = k * (64'(ONE) + my);
		end
		m = p;
		if (r > m) m = r;
		if (q > m) m = q;
		sh = 0;
		while ((m >> sh) >= 64'(ONE)) sh++;
		p = p >> sh;
		r = r >> sh;
		q = q >> sh;
		p2 = p * p;
		r2 = r * r;
		q2 = q * q;
		den = p2 + r2 + q2;
		o.last = v.last;
		if (den == 0) begin
			o.x = 0;
			o.y = ONE;
			o.z = 0;
			return o;
		end
		if (q2 >= p2 + r2) begin
			ym = q2 - (p2 + r2);
			yneg = ny;
		end else begin
			ym = (p2 + r2) - q2;
			yneg = !ny;
		end
		o.x = apply_sign(nx, unit_ratio(2 * p * q, den));
		o.y = apply_sign(yneg, unit_ratio(ym, den));
		o.z = apply_sign(nz, unit_ratio(2 * r * q, den));
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
		errors++;
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, exp_val);
	endtask

	always @(posedge clk) begin
		aberr_vec_t e;
		if (out_valid && out_ready) begin
			if (aberrated_q.size() == 0) begin
				errors++;
				$display("%0t unexpected item out", $realtime);
			end else begin
				e = aberrated_q.pop_front();
				if (out_x !== e.x) report_mismatch("x", out_x, e.x);
				if (out_y !== e.y) report_mismatch("y", out_y, e.y);
				if (out_z !== e.z) report_mismatch("z", out_z, e.z);
				if (out_last !== e.last) report_mismatch("last", out_last, e.last);
			end
		end
	end

	// sink side
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (sink_mode == 1) out_ready <= 1'b1;
			else if (sink_mode == 2) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				sink_mode = 0;
			end else if ($urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 12);
				out_ready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end else out_ready <= 1'b1;
		end
	end

	task automatic send_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
		aberr_vec_t v;
		if (sender_idles && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		v = '{x: x, y: y, z: z, last: last};
		in_valid <= 1'b1;
		in_x <= x;
		in_y <= y;
		in_z <= z;
		in_last <= last;
		aberrated_q.push_back(aberrate(v));
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (aberrated_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (PIPE_LATENCY + 5) @(posedge clk);
	endtask

	task automatic set_rapidity(logic [31:0] k);
		cfg_we <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_we <= 1'b0;
		rapidity = k;
	endtask

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return ONE;
			1: return MINUS_ONE;
			2: return 0;
			3: return $urandom;
			default: return 32'($signed($urandom_range(0, 32'h8000_0000)) - $signed(ONE));
		endcase
	endfunction

	// unit-norm-ish vector: pick two components, derive the third
	task automatic send_unit();
		real a, b, c;
		logic [31:0] xv, yv, zv;
		a = ($urandom_range(0, 2000000) / 1000000.0) - 1.0;
		b = ($urandom_range(0, 2000000) / 1000000.0) - 1.0;
		if (a * a + b * b > 1.0) b = b / 2.0;
		if (a * a + b * b > 1.0) a = a / 2.0;
		c = $sqrt(1.0 - a * a - b * b);
		if ($urandom_range(0, 1)) c = -c;
		xv = 32'($rtoi(a * 1073741824.0));
		yv = 32'($rtoi(c * 1073741824.0));
		zv = 32'($rtoi(b * 1073741824.0));
		send_vec(xv, yv, zv, $urandom_range(0, 1));
	endtask

	task automatic test_directed();
		logic [31:0] ks[4] = '{32'h4000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000};
		foreach (ks[i]) begin
			set_rapidity(ks[i]);
			send_vec(0, ONE, 0, 1'b0);
			send_vec(0, MINUS_ONE, 0, 1'b1);
			send_vec(ONE, 0, 0, 1'b0);
			send_vec(MINUS_ONE, 0, 0, 1'b1);
			send_vec(0, 0, MINUS_ONE, 1'b0);
			send_vec(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
			drain();
		end
	endtask

	task automatic test_random_rapidity();
		logic [31:0] ks[5] = '{32'h2000_0000, 32'h8000_0000, 32'h0000_0001,
			32'hFFFF_FFFF, 32'h4000_0000};
		foreach (ks[i]) begin
			set_rapidity(i == 0 ? $urandom : ks[i]);
			repeat (200) begin
				if ($urandom_range(0, 3) == 0)
					send_vec(rand_comp(), rand_comp(), rand_comp(), $urandom_range(0, 1));
				else send_unit();
			end
			drain();
		end
	endtask

	task automatic test_backpressure();
		sink_mode = 2;
		repeat (150) send_unit();
		drain();
	endtask

	task automatic test_full_rate();
		set_rapidity($urandom_range(32'h1000_0000, 32'h7000_0000));
		sender_idles = 1'b0;
		sink_mode = 1;
		repeat (400) begin
			if ($urandom_range(0, 4) == 0)
				send_vec($urandom, $urandom, $urandom, $urandom_range(0, 1));
			else send_unit();
		end
		drain();
	endtask

	initial begin
		rapidity = ONE;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_rapidity();
		test_backpressure();
		test_full_rate();
		if (errors == 0 && aberrated_q.size() == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule

@@ aberration_unit_vector_unit.f @@
+incdir+hw/rtl
hw/rtl/auv_pkg.sv
hw/rtl/auv_proj.sv
hw/rtl/auv_div.sv
hw/rtl/aberration_unit_vector_unit.sv
hw/rtl/auv_checker.sv
sim/testbench.sv
